// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, register indexes and the side-band record for the
// barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // Temperature term N (t = N / 2^48) and its split for the multipliers
   localparam int NW = 60;
   localparam int NH = 30;

   // Horner partial sums of the pressure polynomial in N
   localparam int H3W  = 33;
   localparam int H2W  = 93;
   localparam int H1W  = 153;
   localparam int ACCW = 214;

   // Pressure rounding: add 2^172, keep bits 197..173
   localparam int PRESS_LSB = 173;
   localparam int PRESS_MSB = 197;

   localparam int CSR_DW = 48;

   typedef enum logic [1:0] {
      CSR_TEMP_TRIM,
      CSR_PRESS_A,
      CSR_PRESS_B,
      CSR_PRESS_C
   } csr_index_type;

   // Data that rides alongside the multiplier chain
   typedef struct packed {
      logic                   ok;
      logic signed [23:0]     tq;
      logic signed [NW-1:0]   n;
      logic signed [ACCW-1:0] c0;
      logic signed [H1W-1:0]  c1;
   } side_type;

endpackage

// ===== rtl/bsc_nmul.sv =====
// ----------------------------------------------------------------------------
// bsc_nmul
// Three-stage multiply-add: prod = addend + a * n, with a cut into 31-bit
// digits and n into two 30-bit halves; partial products, row sums, final add.
// ----------------------------------------------------------------------------
module bsc_nmul import bsc_pkg::*; #(
   parameter int WA = H3W,
   parameter int WR = H2W
) (
   input  logic                 clock,
   input  logic [2:0]           stage_en,
   input  logic signed [WA-1:0] a,
   input  logic signed [NW-1:0] n,
   input  logic signed [WR-1:0] addend,
   output logic signed [WR-1:0] prod
);

   localparam int DG  = 31;
   localparam int ND  = (WA + DG - 1) / DG;
   localparam int AXW = ND * DG + 1;

   logic signed [AXW-1:0] a_ext;
   logic signed [31:0]    dig [ND];
   logic signed [30:0]    n_lo;
   logic signed [30:0]    n_hi;

   logic signed [62:0]    pl_ff [ND];
   logic signed [62:0]    ph_ff [ND];
   logic signed [WR-1:0]  add1_ff;
   logic signed [WR-1:0]  row_lo_in;
   logic signed [WR-1:0]  row_hi_in;
   logic signed [WR-1:0]  row_lo_ff;
   logic signed [WR-1:0]  row_hi_ff;
   logic signed [WR-1:0]  add2_ff;
   logic signed [WR-1:0]  prod_in;
   logic signed [WR-1:0]  prod_ff;

   // lower digits unsigned, top digit carries the sign
   always_comb begin
      a_ext = AXW'(a);
      n_lo  = signed'({1'b0, n[NH-1:0]});
      n_hi  = signed'({n[NW-1], n[NW-1:NH]});
      for (int k = 0; k < ND; k++) begin
         if (k == ND - 1) begin
            dig[k] = a_ext[k*DG +: DG+1];
         end else begin
            dig[k] = signed'({1'b0, a_ext[k*DG +: DG]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int k = 0; k < ND; k++) begin
            pl_ff[k] <= dig[k] * n_lo;
            ph_ff[k] <= dig[k] * n_hi;
         end
         add1_ff <= addend;
      end
   end

   always_comb begin
      row_lo_in = '0;
      row_hi_in = '0;
      for (int k = 0; k < ND; k++) begin
         row_lo_in = row_lo_in + (WR'(pl_ff[k]) <<< (k * DG));
         row_hi_in = row_hi_in + (WR'(ph_ff[k]) <<< (k * DG));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         row_lo_ff <= row_lo_in;
         row_hi_ff <= row_hi_in;
         add2_ff   <= add1_ff;
      end
   end

   assign prod_in = add2_ff + row_lo_ff + (row_hi_ff <<< NH);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Exact fixed-point barometric temperature and pressure compensation.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; the pipeline
// is 14 register stages deep and each stage advances on its own, so bubbles
// close up behind a stalled output.
// The pressure polynomial runs as three Horner steps, three stages each.
// Reset (synchronous): empties the pipeline and clears all four trim registers.
// ----------------------------------------------------------------------------
module baro_sensor_compensation import bsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [23:0]         req_raw_press,
   input  logic [23:0]         req_raw_temp,
   input  logic [7:0]          req_status_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [23:0]  rsp_temp_out,
   output logic [24:0]         rsp_press_out,
   output logic                rsp_ready_res,
   input  logic                csr_wr_en,
   input  csr_index_type       csr_index,
   input  logic [CSR_DW-1:0]   csr_wr_data
);

   // ---------------------------------------------------------------- trims
   logic [39:0] temp_trim_ff;
   logic [47:0] press_a_ff;
   logic [47:0] press_b_ff;
   logic [31:0] press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEMP_TRIM: temp_trim_ff <= csr_wr_data[39:0];
            CSR_PRESS_A:   press_a_ff   <= csr_wr_data;
            CSR_PRESS_B:   press_b_ff   <= csr_wr_data;
            CSR_PRESS_C:   press_c_ff   <= csr_wr_data[31:0];
            default:       temp_trim_ff <= temp_trim_ff;
         endcase
      end
   end

   // Decode coefficients; the user must change trims only while the pipeline is
   // empty, which the block does not enforce; every stage reads them directly.
   logic [15:0]        t1, t2, p5, p6;
   logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
   logic signed [15:0] p1, p2, p9;

   assign t1  = temp_trim_ff[15:0];
   assign t2  = temp_trim_ff[31:16];
   assign t3  = temp_trim_ff[39:32];
   assign p1  = press_a_ff[15:0];
   assign p2  = press_a_ff[31:16];
   assign p3  = press_a_ff[39:32];
   assign p4  = press_a_ff[47:40];
   assign p5  = press_b_ff[15:0];
   assign p6  = press_b_ff[31:16];
   assign p7  = press_b_ff[39:32];
   assign p8  = press_b_ff[47:40];
   assign p9  = press_c_ff[15:0];
   assign p10 = press_c_ff[23:16];
   assign p11 = press_c_ff[31:24];

   // ------------------------------------------------------- flow control
   // A stage advances when it is empty or the stage after it advances.
   logic [14:1] v_ff;
   logic [14:1] v_in;
   logic [14:1] adv;

   assign adv[14] = !v_ff[14] || !rsp_stall;
   for (genvar k = 1; k < 14; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign v_in      = {v_ff[13:1], req_valid};
   assign req_stall = !adv[1];
   assign rsp_valid = v_ff[14];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= 14; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // ------------------------------------------------ stage 1: d = ut - T1
   logic signed [24:0] s1_d_ff;
   logic [23:0]        s1_u_ff;
   logic               s1_ok_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_d_ff  <= signed'({1'b0, req_raw_temp}) - signed'({1'b0, t1, 8'h00});
         s1_u_ff  <= req_raw_press;
         s1_ok_ff <= &req_status_byte[6:4];
      end
   end

   // ---------------------------------------- stage 2: d*T2, d*d, up*up
   logic signed [41:0] s2_dt2_ff;
   logic signed [49:0] s2_dd_ff;
   logic [47:0]        s2_u2_ff;
   logic [23:0]        s2_u_ff;
   logic               s2_ok_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_dt2_ff <= s1_d_ff * signed'({1'b0, t2});
         s2_dd_ff  <= s1_d_ff * s1_d_ff;
         s2_u2_ff  <= s1_u_ff * s1_u_ff;
         s2_u_ff   <= s1_u_ff;
         s2_ok_ff  <= s1_ok_ff;
      end
   end

   // ----------------------------- stage 3: N = d*T2*2^18 + d*d*T3, up^3
   logic signed [57:0]   ddt3;
   logic signed [NW-1:0] n_in;
   logic signed [NW-1:0] s3_n_ff;
   logic [71:0]          s3_u3_ff;
   logic [47:0]          s3_u2_ff;
   logic [23:0]          s3_u_ff;
   logic                 s3_ok_ff;

   always_comb begin
      ddt3 = s2_dd_ff * t3;
      n_in = (NW'(s2_dt2_ff) <<< 18) + NW'(ddt3);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_n_ff  <= n_in;
         s3_u3_ff <= s2_u2_ff * s2_u_ff;
         s3_u2_ff <= s2_u2_ff;
         s3_u_ff  <= s2_u_ff;
         s3_ok_ff <= s2_ok_ff;
      end
   end

   // ------------- stage 4: temperature rounding, polynomial coefficients
   logic signed [24:0]    us;
   logic signed [48:0]    u2s;
   logic signed [72:0]    u3s;
   logic signed [17:0]    p1m, p2m;
   logic signed [32:0]    m_p4, m_p3;
   logic signed [41:0]    m_p2, m_p1;
   logic signed [56:0]    m_p10;
   logic signed [64:0]    m_p9;
   logic signed [80:0]    m_p11;
   logic signed [60:0]    t_rnd;
   logic signed [28:0]    t_q;
   logic signed [23:0]    tq_in;
   side_type              side4_in;
   logic signed [H2W-1:0] c2_in;
   logic signed [H3W-1:0] c3_in;

   always_comb begin
      us    = signed'({1'b0, s3_u_ff});
      u2s   = signed'({1'b0, s3_u2_ff});
      u3s   = signed'({1'b0, s3_u3_ff});
      p1m   = 18'(p1) - 18'sd16384;
      p2m   = 18'(p2) - 18'sd16384;
      m_p4  = us * p4;
      m_p3  = us * p3;
      m_p2  = us * p2m;
      m_p1  = us * p1m;
      m_p10 = u2s * p10;
      m_p9  = u2s * p9;
      m_p11 = u3s * p11;

      // round N / 2^32 to nearest, ties up, then clamp to 24 bits
      t_rnd = 61'(s3_n_ff) + 61'sd2147483648;
      t_q   = t_rnd[60:32];
      priority if (t_q > 29'sd8388607) begin
         tq_in = 24'sh7FFFFF;
      end else if (t_q < -29'sd8388608) begin
         tq_in = 24'sh800000;
      end else begin
         tq_in = t_q[23:0];
      end

      c3_in = (H3W'(p8) <<< 22) + m_p4;
      c2_in = (H2W'(p7) <<< 77) + (H2W'(m_p3) <<< 53);
      side4_in.c1 = (H1W'(signed'({1'b0, p6})) <<< 127)
                  + (H1W'(m_p2) <<< 104) + (H1W'(m_p10) <<< 85);
      side4_in.c0 = (ACCW'(signed'({1'b0, p5})) <<< 184)
                  + (ACCW'(m_p1) <<< 161) + (ACCW'(m_p9) <<< 133)
                  + (ACCW'(m_p11) <<< 116);
      side4_in.ok = s3_ok_ff;
      side4_in.tq = tq_in;
      side4_in.n  = s3_n_ff;
   end

   side_type              side_ff [4:13];
   logic signed [H2W-1:0] s4_c2_ff;
   logic signed [H3W-1:0] s4_c3_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         side_ff[4] <= side4_in;
         s4_c2_ff   <= c2_in;
         s4_c3_ff   <= c3_in;
      end
      // carry N, the remaining coefficients and the temperature result
      for (int k = 5; k <= 13; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // -------------------------------------------- stages 5..13: Horner in N
   logic signed [H2W-1:0]  h2;
   logic signed [H1W-1:0]  h1;
   logic signed [ACCW-1:0] acc;

   bsc_nmul #(.WA(H3W), .WR(H2W)) u_step2 (
      .clock    (clock),
      .stage_en (adv[7:5]),
      .a        (s4_c3_ff),
      .n        (side_ff[4].n),
      .addend   (s4_c2_ff),
      .prod     (h2)
   );

   bsc_nmul #(.WA(H2W), .WR(H1W)) u_step1 (
      .clock    (clock),
      .stage_en (adv[10:8]),
      .a        (h2),
      .n        (side_ff[7].n),
      .addend   (side_ff[7].c1),
      .prod     (h1)
   );

   bsc_nmul #(.WA(H1W), .WR(ACCW)) u_step0 (
      .clock    (clock),
      .stage_en (adv[13:11]),
      .a        (h1),
      .n        (side_ff[10].n),
      .addend   (side_ff[10].c0),
      .prod     (acc)
   );

   // ------------------------- stage 14: pressure rounding, output register
   logic signed [ACCW-1:0] p_rnd;
   logic [24:0]            press_in;
   logic signed [23:0]     rsp_temp_ff;
   logic [24:0]            rsp_press_ff;
   logic                   rsp_ready_ff;

   always_comb begin
      p_rnd = acc + (ACCW'(1) <<< (PRESS_LSB - 1));
      priority if (p_rnd[ACCW-1]) begin
         press_in = '0;
      end else if (|p_rnd[ACCW-2:PRESS_MSB+1]) begin
         press_in = '1;
      end else begin
         press_in = p_rnd[PRESS_MSB:PRESS_LSB];
      end
   end

   // drop the values of a beat whose status bits were not all set
   always_ff @(posedge clock) begin
      if (adv[14]) begin
         rsp_ready_ff <= side_ff[13].ok;
         rsp_temp_ff  <= side_ff[13].ok ? side_ff[13].tq : '0;
         rsp_press_ff <= side_ff[13].ok ? press_in : '0;
      end
   end

   assign rsp_temp_out  = rsp_temp_ff;
   assign rsp_press_out = rsp_press_ff;
   assign rsp_ready_res = rsp_ready_ff;

   // ------------------------------------------------------------ checks
   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready_res |-> rsp_temp_out == '0 && rsp_press_out == '0)
      else $error("not-ready beat carries non-zero values");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> &v_ff)
      else $error("request stalled with a bubble in the pipeline");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(v_ff) == $past($countones(v_ff))
         + $past(int'(req_valid && !req_stall)) - $past(int'(rsp_valid && !rsp_stall)))
      else $error("beat lost or duplicated in the pipeline");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw temperature and pressure beats through the compensation pipeline
// under several trim settings and idling mixes. Each beat is checked against a
// typed result or an exact wide-integer predictor of the compensation polynomial.
// ----------------------------------------------------------------------------
module testbench;
   import bsc_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [23:0]        raw_press;
      logic [23:0]        raw_temp;
      logic [7:0]         status;
      bit                 known;      // expected result typed into the row
      logic signed [23:0] temp;
      logic [24:0]        press;
      logic               ready;
   } beat_type;

   localparam int LIMIT    = 400000;
   localparam int LATENCY  = 14;
   localparam int PER_MIX  = 170;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [23:0]         req_raw_press = '0;
   logic [23:0]         req_raw_temp = '0;
   logic [7:0]          req_status_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [23:0]  rsp_temp_out;
   logic [24:0]         rsp_press_out;
   logic                rsp_ready_res;
   logic                csr_wr_en = 1'b0;
   csr_index_type       csr_index = CSR_TEMP_TRIM;
   logic [CSR_DW-1:0]   csr_wr_data = '0;

   // trim copies held by the predictor
   logic [39:0] temp_trim;
   logic [47:0] press_trim_a;
   logic [47:0] press_trim_b;
   logic [31:0] press_trim_c;

   beat_type    pending_results[$];
   beat_type    directed_rows[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   bit          holdoff_req = 1'b0;
   bit          holdoff_done = 1'b0;
   int          holdoff_left = 0;

   baro_sensor_compensation dut (.*);

   always #1 clock = ~clock;

   // Exact compensation: temperature as N / 2^48, pressure as R / 2^181
   function automatic beat_type compensate(input logic [23:0] up_raw,
                                           input logic [23:0] ut_raw,
                                           input logic [7:0] st);
      beat_type r;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
      longint up, d, n;
      logic signed [65:0] tq;
      wide_type nw, n2, n3, u2, acc;
      r.raw_press = up_raw;
      r.raw_temp = ut_raw;
      r.status = st;
      r.known = 1'b0;
      r.temp = '0;
      r.press = '0;
      r.ready = 1'b0;
      if ((st & 8'h70) != 8'h70) return r;
      t1  = temp_trim[15:0];
      t2  = temp_trim[31:16];
      t3  = signed'(temp_trim[39:32]);
      p1  = signed'(press_trim_a[15:0]);
      p2  = signed'(press_trim_a[31:16]);
      p3  = signed'(press_trim_a[39:32]);
      p4  = signed'(press_trim_a[47:40]);
      p5  = press_trim_b[15:0];
      p6  = press_trim_b[31:16];
      p7  = signed'(press_trim_b[39:32]);
      p8  = signed'(press_trim_b[47:40]);
      p9  = signed'(press_trim_c[15:0]);
      p10 = signed'(press_trim_c[23:16]);
      p11 = signed'(press_trim_c[31:24]);
      up  = up_raw;
      d   = longint'(ut_raw) - t1 * 256;
      n   = d * t2 * 262144 + d * d * t3;
      // round N / 2^32 to nearest, ties upward, then clamp
      tq = (66'(signed'(n)) + 66'sd2147483648) >>> 32;
      if (tq > 66'sd8388607) tq = 66'sd8388607;
      if (tq < -66'sd8388608) tq = -66'sd8388608;
      r.temp = tq[23:0];
      nw  = wide_type'(n);
      n2  = nw * nw;
      n3  = n2 * nw;
      u2  = wide_type'(up) * wide_type'(up);
      acc = wide_type'(p5) << 184;
      acc += (wide_type'(p6) * nw) << 127;
      acc += (wide_type'(p7) * n2) << 77;
      acc += (wide_type'(p8) * n3) << 22;
      acc += wide_type'(up * (p1 - 16384)) << 161;
      acc += (wide_type'(up * (p2 - 16384)) * nw) << 104;
      acc += (wide_type'(up * p3) * n2) << 53;
      acc += wide_type'(up * p4) * n3;
      acc += (u2 * wide_type'(p9)) << 133;
      acc += ((u2 * wide_type'(p10)) * nw) << 85;
      acc += (u2 * wide_type'(up * p11)) << 116;
      acc += wide_type'(1) << 172;
      if (acc[255]) r.press = '0;
      else if (acc[255:198] != '0) r.press = '1;
      else r.press = acc[197:173];
      r.ready = 1'b1;
      return r;
   endfunction

   function automatic beat_type typed_row(input logic [23:0] up, input logic [23:0] ut,
                                          input logic [7:0] st,
                                          input logic signed [23:0] t,
                                          input logic [24:0] p, input logic rdy);
      beat_type r;
      r.raw_press = up;
      r.raw_temp = ut;
      r.status = st;
      r.known = 1'b1;
      r.temp = t;
      r.press = p;
      r.ready = rdy;
      return r;
   endfunction

   // Receiver: random stall, or one long hold-off counted here when asked
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else if (holdoff_req && !holdoff_done) begin
         holdoff_left <= 80;
         holdoff_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin
      beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: temp %0d press %0d ready %0b",
                        rsp_temp_out, rsp_press_out, rsp_ready_res);
         end else begin
            e = pending_results.pop_front();
            if (rsp_temp_out !== e.temp || rsp_press_out !== e.press
                || rsp_ready_res !== e.ready) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch raw p %h t %h st %h: exp %0d/%0d/%0b got %0d/%0d/%0b",
                           e.raw_press, e.raw_temp, e.status, e.temp, e.press, e.ready,
                           rsp_temp_out, rsp_press_out, rsp_ready_res);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Write one trim register; the predictor copy is masked to its width
   task automatic csr_write(input csr_index_type idx, input logic [47:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_TEMP_TRIM: temp_trim = data[39:0];
         CSR_PRESS_A:   press_trim_a = data;
         CSR_PRESS_B:   press_trim_b = data;
         CSR_PRESS_C:   press_trim_c = data[31:0];
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drain outstanding beats, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Offer one beat, with random idle cycles ahead of it; called at negedge
   task automatic send_beat(input beat_type b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_press <= b.raw_press;
      req_raw_temp <= b.raw_temp;
      req_status_byte <= b.status;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      if (!b.known) b = compensate(b.raw_press, b.raw_temp, b.status);
      pending_results.push_back(b);
      @(negedge clock);
   endtask

   // Typical trims with some jitter, so results land mostly in range
   task automatic load_typical();
      logic [15:0] t1;
      t1 = 16'd27500 + 16'($urandom_range(2000));
      csr_write(CSR_TEMP_TRIM, {8'd0, 8'hF9, 16'd19000 + 16'($urandom_range(500)), t1});
      csr_write(CSR_PRESS_A, {8'h01, 8'h08, 16'h0010 ^ 16'($urandom_range(255)),
                              16'h1A40 ^ 16'($urandom_range(255))});
      csr_write(CSR_PRESS_B, {8'h00, 8'hFB, 16'd15500, 16'd27000 + 16'($urandom_range(99))});
      csr_write(CSR_PRESS_C, {8'h05, 8'h00, 16'd3000 + 16'($urandom_range(999))});
   endtask

   function automatic beat_type random_beat();
      beat_type b;
      b.known = 1'b0;
      // mostly plausible readings near the trim point, some noise
      if ($urandom_range(9) < 7)
         b.raw_temp = {temp_trim[15:0], 8'h00} + 24'($urandom_range(2097152)) - 24'd1048576;
      else
         b.raw_temp = 24'($urandom);
      if ($urandom_range(9) < 7)
         b.raw_press = 24'd5000000 + 24'($urandom_range(4000000));
      else
         b.raw_press = 24'($urandom);
      if ($urandom_range(9) < 8) b.status = 8'($urandom) | 8'h70;
      else b.status = 8'($urandom);
      return b;
   endfunction

   initial begin
      int mix;
      temp_trim = '0;
      press_trim_a = '0;
      press_trim_b = '0;
      press_trim_c = '0;

      // reset-state rows: zero trims give zero temperature and zero pressure
      directed_rows.push_back(typed_row(24'h000000, 24'h000000, 8'h70, '0, '0, 1'b1));
      directed_rows.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 8'hFF, '0, '0, 1'b1));
      directed_rows.push_back(typed_row(24'h800000, 24'h7FFFFF, 8'h7F, '0, '0, 1'b1));
      // not ready: each one of the three status bits missing, others ignored
      directed_rows.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 8'h00, '0, '0, 1'b0));
      directed_rows.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 8'hEF, '0, '0, 1'b0));
      directed_rows.push_back(typed_row(24'h123456, 24'hABCDEF, 8'hDF, '0, '0, 1'b0));
      directed_rows.push_back(typed_row(24'h654321, 24'h000001, 8'hBF, '0, '0, 1'b0));
      directed_rows.push_back(typed_row(24'h000000, 24'hFFFFFF, 8'h8F, '0, '0, 1'b0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_beat(directed_rows[i]);
      drain();

      // extremes of the readings under typical, all-ones and mixed trims
      for (int c = 0; c < 3; c++) begin
         if (c == 0) load_typical();
         else if (c == 1) begin
            csr_write(CSR_TEMP_TRIM, '1);
            csr_write(CSR_PRESS_A, '1);
            csr_write(CSR_PRESS_B, '1);
            csr_write(CSR_PRESS_C, '1);
         end else begin
            // large positive slope: pressure clamps high, temperature too for high readings
            csr_write(CSR_TEMP_TRIM, 48'h00_7F_FFFF_0000);
            csr_write(CSR_PRESS_A, 48'h7F_7F_7FFF_7FFF);
            csr_write(CSR_PRESS_B, 48'h7F_7F_FFFF_FFFF);
            csr_write(CSR_PRESS_C, 48'h0000_7F7F_7FFF);
         end
         send_beat(compensate(24'h000000, 24'h000000, 8'h70));
         send_beat(compensate(24'hFFFFFF, 24'hFFFFFF, 8'h70));
         send_beat(compensate(24'hFFFFFF, 24'h000000, 8'hF0));
         send_beat(compensate(24'h000000, 24'hFFFFFF, 8'h70));
         send_beat(compensate(24'h600000, 24'h6B0000, 8'h70));
         drain();
      end

      // random part: one idling mix per phase, fresh trims each time
      for (mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
         endcase
         if (mix == 3) begin
            csr_write(CSR_TEMP_TRIM, 48'({$urandom, $urandom}));
            csr_write(CSR_PRESS_A, 48'({$urandom, $urandom}));
            csr_write(CSR_PRESS_B, 48'({$urandom, $urandom}));
            csr_write(CSR_PRESS_C, 48'($urandom));
         end else begin
            load_typical();
         end
         for (int k = 0; k < PER_MIX; k++) begin
            // back-pressure burst: the pipeline fills and stalls its input
            if (mix == 0 && k == 40) holdoff_req = 1'b1;
            if (mix == 0 && k == 45) holdoff_req = 1'b0;
            // sender pause until every beat has come back
            if (mix == 2 && k == 80) begin
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(negedge clock);
            end
            // stretches with no idling inside the busy mixes
            if (mix != 0 && k == 120) begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            send_beat(random_beat());
         end
         drain();
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bsc_pkg.sv
rtl/bsc_nmul.sv
rtl/baro_sensor_compensation.sv
dv/testbench.sv
